FILE: hdl/rsrd_pkg.sv
`default_nettype none
package rsrd_pkg;

   // Field widths
   localparam int ByteW    = 8;
   localparam int ColW     = 10;
   localparam int WidthW   = 16;
   // Fill position covers 4 * 65535 plus one command overrun of up to 127 bytes
   localparam int FillW    = 19;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 32;

   // Request kinds carried on tuser
   localparam logic KindByte = 1'b0;
   localparam logic KindRead = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;       // request accepted: clear the working result
      logic load_whi;    // load high width byte
      logic load_wlo;    // load low width byte, clear fill, flag oversize
      logic load_lit;    // load literal count from command byte
      logic load_run;    // load run count from command byte
      logic load_sym;    // latch run symbol
      logic put_lit;     // store request byte, advance fill
      logic put_run;     // store run symbol, advance fill
      logic clear_fill;  // restart fill at line end
      logic set_done;    // mark result as line end
      logic rd_start;    // load read address from column
      logic rd_issue;    // read one plane, step address by width
      logic load_out;    // move working result to output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cmd_run;     // command byte is a run
      logic cmd_zero;    // command byte is zero
      logic lit_last;    // one literal left
      logic run_zero;    // run count is zero
      logic run_last;    // one run byte left
      logic fill_done;   // line has all its bytes
      logic rd_ok;       // read column inside a valid line
      logic out_free;    // output register can take a result
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/rsrd_ctrl.sv
`default_nettype none
module rsrd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               req_tuser,
   input  wire rsrd_pkg::status_type st,
   output rsrd_pkg::cmd_type       cmd
);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_OUT    = 3'd1;
   localparam logic [2:0] S_RUN    = 3'd2;
   localparam logic [2:0] S_FIN    = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_RDLAST = 3'd5;

   // Decode phases
   localparam logic [2:0] PH_MARK1 = 3'd0;
   localparam logic [2:0] PH_MARK2 = 3'd1;
   localparam logic [2:0] PH_WHI   = 3'd2;
   localparam logic [2:0] PH_WLO   = 3'd3;
   localparam logic [2:0] PH_CMD   = 3'd4;
   localparam logic [2:0] PH_LIT   = 3'd5;
   localparam logic [2:0] PH_RUN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic [1:0] rd_cnt_ff, rd_cnt_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   // Sequence one request and the decode phase
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      rd_cnt_in = rd_cnt_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in  = S_OUT;
               if (req_tuser == rsrd_pkg::KindRead) begin
                  if (st.rd_ok) begin
                     cmd.rd_start = 1'b1;
                     rd_cnt_in    = '0;
                     state_in     = S_READ;
                  end
               end else begin
                  case (phase_ff)
                     PH_MARK1: phase_in = PH_MARK2;
                     PH_MARK2: phase_in = PH_WHI;
                     PH_WHI: begin
                        cmd.load_whi = 1'b1;
                        phase_in     = PH_WLO;
                     end
                     PH_WLO: begin
                        cmd.load_wlo = 1'b1;
                        state_in     = S_FIN;
                     end
                     PH_CMD: begin
                        if (st.cmd_run) begin
                           cmd.load_run = 1'b1;
                           phase_in     = PH_RUN;
                        end else begin
                           cmd.load_lit = 1'b1;
                           phase_in     = st.cmd_zero ? PH_CMD : PH_LIT;
                        end
                     end
                     PH_LIT: begin
                        cmd.put_lit = 1'b1;
                        if (st.lit_last) begin
                           state_in = S_FIN;
                        end
                     end
                     PH_RUN: begin
                        if (st.run_zero) begin
                           state_in = S_FIN;
                        end else begin
                           cmd.load_sym = 1'b1;
                           state_in     = S_RUN;
                        end
                     end
                     default: phase_in = PH_MARK1;
                  endcase
               end
            end
         end
         // Expand the run, one store entry a cycle
         S_RUN: begin
            cmd.put_run = 1'b1;
            if (st.run_last) begin
               state_in = S_FIN;
            end
         end
         // Close the command: end the line or wait for the next command
         S_FIN: begin
            state_in = S_OUT;
            if (st.fill_done) begin
               cmd.set_done   = 1'b1;
               cmd.clear_fill = 1'b1;
               phase_in       = PH_MARK1;
            end else begin
               phase_in = PH_CMD;
            end
         end
         // Read the four planes of one column
         S_READ: begin
            cmd.rd_issue = 1'b1;
            rd_cnt_in    = rd_cnt_ff + 2'd1;
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_RDLAST;
            end
         end
         S_RDLAST: state_in = S_OUT;
         // Hold the result until the output register is free
         S_OUT: begin
            if (st.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_MARK1;
         rd_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/rsrd_dpath.sv
`default_nettype none
module rsrd_dpath #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rsrd_pkg::cmd_type             cmd,
   output rsrd_pkg::status_type               st,
   input  wire logic [rsrd_pkg::ByteW-1:0]    req_data_byte,
   input  wire logic [rsrd_pkg::ColW-1:0]     req_column,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,
   output logic [rsrd_pkg::RspDataW-1:0]      rsp_tdata
);

   localparam int StoreDepth = 4 * MAX_WIDTH;
   localparam int AddrW      = $clog2(StoreDepth);

   // Line store, planar: red, green, blue, exponent
   logic [rsrd_pkg::ByteW-1:0] line_mem [StoreDepth];

   logic [rsrd_pkg::WidthW-1:0] width_ff, width_in;
   logic [rsrd_pkg::FillW-1:0]  fill_ff, fill_in;
   logic [6:0]                  lit_ff, lit_in;
   logic [6:0]                  run_ff, run_in;
   logic [rsrd_pkg::ByteW-1:0]  sym_ff;
   logic [AddrW-1:0]            rd_addr_ff;
   logic                        rd_pend_ff;
   logic [rsrd_pkg::ByteW-1:0]  mem_q_ff;
   logic [rsrd_pkg::ByteW-1:0]  red_ff, green_ff, blue_ff, expo_ff;
   logic                        done_ff, werr_ff;
   logic                        out_valid_ff;
   logic                        out_last_ff, out_user_ff;
   logic [rsrd_pkg::RspDataW-1:0] out_data_ff;

   logic [rsrd_pkg::FillW-1:0]  target;
   logic [rsrd_pkg::WidthW-1:0] width_lo;
   logic                        wr_en;
   logic [rsrd_pkg::ByteW-1:0]  wr_data;

   assign target   = rsrd_pkg::FillW'({width_ff, 2'b00});
   assign width_lo = {width_ff[15:8], req_data_byte};
   assign wr_en    = (cmd.put_lit || cmd.put_run) && (fill_ff < target)
                     && (fill_ff < rsrd_pkg::FillW'(StoreDepth));
   assign wr_data  = cmd.put_lit ? req_data_byte : sym_ff;

   // Status for the controller
   always_comb begin
      st.cmd_run   = req_data_byte[7];
      st.cmd_zero  = (req_data_byte == '0);
      st.lit_last  = (lit_ff == 7'd1);
      st.run_zero  = (run_ff == 7'd0);
      st.run_last  = (run_ff == 7'd1);
      st.fill_done = (fill_ff >= target);
      st.rd_ok     = (width_ff <= rsrd_pkg::WidthW'(MAX_WIDTH))
                     && (rsrd_pkg::WidthW'(req_column) < width_ff);
      st.out_free  = !out_valid_ff || rsp_tready;
   end

   // Next width, fill and counters
   always_comb begin
      width_in = width_ff;
      fill_in  = fill_ff;
      lit_in   = lit_ff;
      run_in   = run_ff;
      if (cmd.load_whi) begin
         width_in = {req_data_byte, 8'h00};
      end
      if (cmd.load_wlo) begin
         width_in = width_lo;
         fill_in  = '0;
      end
      if (cmd.load_lit) begin
         lit_in = req_data_byte[6:0];
      end
      if (cmd.load_run) begin
         run_in = req_data_byte[6:0];
      end
      if (cmd.put_lit) begin
         fill_in = fill_ff + 1'b1;
         lit_in  = lit_ff - 7'd1;
      end
      if (cmd.put_run) begin
         fill_in = fill_ff + 1'b1;
         run_in  = run_ff - 7'd1;
      end
      if (cmd.clear_fill) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= '0;
         fill_ff      <= '0;
         lit_ff       <= '0;
         run_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         fill_ff    <= fill_in;
         lit_ff     <= lit_in;
         run_ff     <= run_in;
         rd_pend_ff <= cmd.rd_issue;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Write the line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[AddrW-1:0]] <= wr_data;
      end
   end

   // Read the line store, one plane a cycle
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         mem_q_ff <= line_mem[rd_addr_ff];
      end
   end

   // Symbol, read address and working result
   always_ff @(posedge clock) begin
      if (cmd.load_sym) begin
         sym_ff <= req_data_byte;
      end
      if (cmd.rd_start) begin
         rd_addr_ff <= AddrW'(req_column);
      end else if (cmd.rd_issue) begin
         rd_addr_ff <= rd_addr_ff + AddrW'(width_ff);
      end
      if (cmd.start) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         expo_ff  <= '0;
         done_ff  <= 1'b0;
         werr_ff  <= 1'b0;
      end else begin
         if (rd_pend_ff) begin
            red_ff   <= green_ff;
            green_ff <= blue_ff;
            blue_ff  <= expo_ff;
            expo_ff  <= mem_q_ff;
         end
         if (cmd.set_done) begin
            done_ff <= 1'b1;
         end
      end
      if (cmd.load_wlo) begin
         werr_ff <= (width_lo > rsrd_pkg::WidthW'(MAX_WIDTH));
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_last_ff <= done_ff;
         out_user_ff <= werr_ff;
         out_data_ff <= {expo_ff, blue_ff, green_ff, red_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

FILE: hdl/rgbe_scanline_rle_decoder_top.sv
`default_nettype none
// Channel  | Ports             | Payload
// request  | req_t*  (in)      | tuser: kind; tdata: data_byte [7:0], column [17:8]
// response | rsp_t*  (out)     | tlast: line_done; tuser: width_error;
//          |                   | tdata: red, green, blue, exponent (low to high)
//
// Path of a request from acceptance to result in the output register: header
// and plain bytes go straight to output; the low width byte and the last literal
// of a command close the command first; a run symbol byte stores its run (one
// line store write a cycle), then closes; a column read takes the four planes
// through the single store read port; a column outside the line goes to output.
// One request is in work at a time; a finished result may wait in the output
// register while the next request is taken. Reset is synchronous and clears
// the decode state; the line store is not cleared. No request is taken in reset.
module rgbe_scanline_rle_decoder_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic                          req_tuser,   // kind
   input  wire logic [rsrd_pkg::ReqDataW-1:0] req_tdata,   // data_byte, column, zero pad
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tlast,   // line_done
   output logic                               rsp_tuser,   // width_error
   output logic [rsrd_pkg::RspDataW-1:0]      rsp_tdata    // red, green, blue, exponent
);

   rsrd_pkg::cmd_type    cmd;
   rsrd_pkg::status_type st;

   rsrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   rsrd_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_data_byte (req_tdata[7:0]),
      .req_column    (req_tdata[17:8]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: hdl/rsrd_check.sv
`default_nettype none
module rsrd_check (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic                          rsp_tlast,
   input wire logic                          rsp_tuser,
   input wire logic [rsrd_pkg::RspDataW-1:0] rsp_tdata
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Come out of reset with no response pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // Take one request at a time
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // Line end only on byte requests, which carry no pixel
   a_done_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == '0)
      else $error("line end with pixel data");

   // Oversized width never ends a line on the same byte
   a_werr_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && rsp_tdata == '0)
      else $error("width error with line end or pixel data");

endmodule

bind rgbe_scanline_rle_decoder_top rsrd_check u_rsrd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

FILE: tb/tb_rgbe_scanline_rle_decoder_top.sv
`default_nettype none
module tb_rgbe_scanline_rle_decoder_top;

   localparam int          MAX_WIDTH   = 1024;
   localparam int unsigned STORE_DEPTH = 4 * MAX_WIDTH;
   localparam int          HOLD_CYCLES = 300;
   localparam int          STALL_LIMIT = 2000;
   localparam int          DRAIN_CYCLES = 32;

   // scanline decode phases
   typedef enum logic [2:0] {
      SCAN_MARK1,
      SCAN_MARK2,
      SCAN_WIDTH_HI,
      SCAN_WIDTH_LO,
      SCAN_COMMAND,
      SCAN_LITERAL,
      SCAN_RUN
   } scan_phase_type;

   typedef struct packed {
      logic       line_done;
      logic       width_error;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] exponent;
   } pixel_result_type;

   typedef struct {
      logic             kind;
      logic [7:0]       data_byte;
      logic [9:0]       column;
      pixel_result_type want;
   } decode_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic                               req_tuser = 1'b0;  // kind
   logic [rsrd_pkg::ReqDataW-1:0]      req_tdata = '0;    // data_byte, column, zero pad
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               rsp_tlast;         // line_done
   logic                               rsp_tuser;         // width_error
   logic [rsrd_pkg::RspDataW-1:0]      rsp_tdata;         // red, green, blue, exponent

   rgbe_scanline_rle_decoder_top #(
      .MAX_WIDTH (MAX_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // decoder shadow state
   scan_phase_type scan_phase = SCAN_MARK1;
   logic [15:0] line_width = '0;
   int unsigned fill_pos = 0;
   logic [6:0]  literals_left = '0;
   int unsigned run_left = 0;
   logic [7:0]  line_store [STORE_DEPTH];
   bit          store_written [STORE_DEPTH];

   decode_request_type pending_requests[$];
   pixel_result_type   expected_pixels[$];

   int items_made = 0;
   int read_pct = 15;
   int src_idle_pct = 9;
   int sink_idle_pct = 77;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int fail_count = 0;
   int stall_cycles = 0;

   decode_request_type in_flight;
   pixel_result_type   seen_pixel;
   pixel_result_type   oldest_pixel;

   // write one decoded byte, dropping it past the line end or the store end
   function automatic void store_byte(logic [7:0] b);
      if (fill_pos < 4 * line_width && fill_pos < STORE_DEPTH) begin
         line_store[fill_pos] = b;
         store_written[fill_pos] = 1'b1;
      end
      fill_pos++;
   endfunction

   // close a command; report whether the line is complete
   function automatic logic end_command();
      if (fill_pos >= 4 * line_width) begin
         scan_phase = SCAN_MARK1;
         fill_pos = 0;
         return 1'b1;
      end
      scan_phase = SCAN_COMMAND;
      return 1'b0;
   endfunction

   // advance the shadow decoder by one request and return its response
   function automatic pixel_result_type decode_request(logic kind, logic [7:0] b,
                                                       logic [9:0] col);
      pixel_result_type res;
      int unsigned      k;
      int unsigned      lw;
      res = '0;
      lw = line_width;
      if (kind == rsrd_pkg::KindRead) begin
         if (lw <= MAX_WIDTH && col < lw) begin
            res.red      = line_store[col];
            res.green    = line_store[col + lw];
            res.blue     = line_store[col + 2 * lw];
            res.exponent = line_store[col + 3 * lw];
         end
         return res;
      end
      case (scan_phase)
         SCAN_MARK1: scan_phase = SCAN_MARK2;
         SCAN_MARK2: scan_phase = SCAN_WIDTH_HI;
         SCAN_WIDTH_HI: begin
            line_width = {b, 8'h00};
            scan_phase = SCAN_WIDTH_LO;
         end
         SCAN_WIDTH_LO: begin
            line_width[7:0] = b;
            fill_pos = 0;
            res.width_error = (line_width > MAX_WIDTH);
            res.line_done = end_command();
         end
         SCAN_COMMAND: begin
            if (b <= 8'd127) begin
               literals_left = b[6:0];
               scan_phase = (b == 8'd0) ? SCAN_COMMAND : SCAN_LITERAL;
            end else begin
               run_left = b - 8'd128;
               scan_phase = SCAN_RUN;
            end
         end
         SCAN_LITERAL: begin
            store_byte(b);
            literals_left = literals_left - 7'd1;
            if (literals_left == 7'd0) res.line_done = end_command();
         end
         SCAN_RUN: begin
            for (k = 0; k < run_left; k++) store_byte(b);
            run_left = 0;
            res.line_done = end_command();
         end
         default: scan_phase = SCAN_MARK1;
      endcase
      return res;
   endfunction

   // predict and queue one request
   task automatic send_item(logic kind, logic [7:0] b, logic [9:0] col);
      decode_request_type item;
      item.kind = kind;
      item.data_byte = b;
      item.column = col;
      item.want = decode_request(kind, b, col);
      pending_requests.insert(pending_requests.size(), item);
      items_made++;
   endtask

   // stream byte with a random value in the unused column field
   task automatic send_byte(logic [7:0] b);
      send_item(rsrd_pkg::KindByte, b, 10'($urandom_range(1023)));
   endtask

   // read a column whose store entries are known, or one outside the line
   task automatic send_read();
      logic [9:0]  col;
      bit          found;
      int unsigned lw;
      int          t;
      found = 1'b0;
      col = '0;
      lw = line_width;
      for (t = 0; t < 8 && !found; t++) begin
         if (lw >= 1 && lw <= MAX_WIDTH && $urandom_range(99) < 70)
            col = 10'($urandom_range(lw - 1));
         else
            col = 10'($urandom_range(1023));
         if (lw > MAX_WIDTH || col >= lw)
            found = 1'b1;
         else
            found = store_written[col] && store_written[col + lw] &&
                    store_written[col + 2 * lw] && store_written[col + 3 * lw];
      end
      if (found) send_item(rsrd_pkg::KindRead, 8'($urandom_range(255)), col);
   endtask

   task automatic maybe_read();
      if ($urandom_range(99) < read_pct) send_read();
   endtask

   // one encoded scanline: header, then literal and run commands with random content
   task automatic send_line(int unsigned width, bit long_literal);
      int unsigned need;
      int unsigned n;
      int unsigned cap;
      int unsigned pick;
      bit          run_heavy;
      bit          overrun;
      send_byte(8'($urandom_range(255)));
      maybe_read();
      send_byte(8'($urandom_range(255)));
      maybe_read();
      send_byte(width[15:8]);
      maybe_read();
      send_byte(width[7:0]);
      need = 4 * width;
      run_heavy = (width > 64);
      while (need > 0) begin
         maybe_read();
         pick = $urandom_range(99);
         cap = (need < 127) ? need : 127;
         overrun = (need < 100) && ($urandom_range(99) < 15);
         if (long_literal && cap == 127) begin
            // longest literal command
            long_literal = 1'b0;
            send_byte(8'd127);
            repeat (127) send_byte(8'($urandom_range(255)));
            need -= 127;
         end else if (pick < 4) begin
            // empty command: no bytes produced
            if (pick % 2 == 0) begin
               send_byte(8'd0);
            end else begin
               send_byte(8'd128);
               send_byte(8'($urandom_range(255)));
            end
         end else if (pick < (run_heavy ? 90 : 40)) begin
            if (overrun) n = $urandom_range(127, need + 1);
            else if (run_heavy && cap == 127 && pick % 4 != 0) n = 127;
            else n = $urandom_range(cap, 1);
            send_byte(8'(128 + n));
            maybe_read();
            send_byte(8'($urandom_range(255)));
            need -= (n < need) ? n : need;
         end else begin
            if (overrun) n = $urandom_range((need + 8 > 127) ? 127 : need + 8, need + 1);
            else n = $urandom_range((cap < 12) ? cap : 12, 1);
            send_byte(8'(n));
            repeat (n) begin
               maybe_read();
               send_byte(8'($urandom_range(255)));
            end
            need -= (n < need) ? n : need;
         end
      end
   endtask

   function automatic int unsigned random_width();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return $urandom_range(1040, MAX_WIDTH + 1);
      if (r < 5) return MAX_WIDTH;
      if (r < 10) return 0;
      if (r < 70) return $urandom_range(8, 1);
      return $urandom_range(40, 9);
   endfunction

   // block until every queued request has been answered
   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_pixels.insert(expected_pixels.size(), in_flight.want);
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= in_flight.kind;
               req_tdata <= {6'b0, in_flight.column, in_flight.data_byte};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_pixel = '{line_done: rsp_tlast, width_error: rsp_tuser,
                           red: rsp_tdata[7:0], green: rsp_tdata[15:8],
                           blue: rsp_tdata[23:16], exponent: rsp_tdata[31:24]};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: done %0b werr %0b rgbe %h",
                           seen_pixel.line_done, seen_pixel.width_error,
                           rsp_tdata);
               fail_count++;
            end else begin
               oldest_pixel = expected_pixels.pop_front();
               if (seen_pixel !== oldest_pixel) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected done %0b werr %0b r %h g %h b %h e %h",
                              oldest_pixel.line_done, oldest_pixel.width_error,
                              oldest_pixel.red, oldest_pixel.green,
                              oldest_pixel.blue, oldest_pixel.exponent);
                     $display("          got      done %0b werr %0b r %h g %h b %h e %h",
                              seen_pixel.line_done, seen_pixel.width_error,
                              seen_pixel.red, seen_pixel.green,
                              seen_pixel.blue, seen_pixel.exponent);
                  end
                  fail_count++;
               end
            end
         end
         // start a long hold-off when one is requested
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // watchdog: end the run when no request or response moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", stall_cycles);
         $display("** rgbe_scanline_rle_decoder_top: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty line: the low width byte completes it
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      // two-column line: empty literal, empty run, literals, a run, a run past the end
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'd0);
      send_byte(8'd128);
      send_byte(8'h3C);
      send_byte(8'd3);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h81);
      send_byte(8'd130);
      send_byte(8'hC3);
      send_byte(8'd255);
      send_byte(8'h7E);
      // reads inside, at the edge of and far outside the line
      send_item(rsrd_pkg::KindRead, 8'h00, 10'd0);
      send_item(rsrd_pkg::KindRead, 8'hFF, 10'd1);
      send_item(rsrd_pkg::KindRead, 8'h00, 10'd2);
      send_item(rsrd_pkg::KindRead, 8'hFF, 10'd1023);

      // sender mostly busy, receiver mostly stalled; one long hold-off
      hold_requests++;
      send_line(MAX_WIDTH, 1'b1);
      while (items_made < 360) send_line(random_width(), 1'b0);
      wait_for_drain();

      // sender mostly idle, receiver mostly ready; start with an oversized line
      src_idle_pct = 77;
      sink_idle_pct = 9;
      send_line($urandom_range(1040, MAX_WIDTH + 1), 1'b0);
      while (items_made < 700) send_line(random_width(), 1'b0);
      wait_for_drain();

      // no idling on either side, one more hold-off
      src_idle_pct = 0;
      sink_idle_pct = 0;
      hold_requests++;
      while (items_made < 1040) send_line(random_width(), 1'b0);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_pixels.size() == 0) begin
         $display("** rgbe_scanline_rle_decoder_top: PASSED **");
      end else begin
         $display("** rgbe_scanline_rle_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
